[rtl/core/blid_pkg.sv]
`default_nettype none

package blid_pkg;

   // Wide enough for any count or position the ports can carry
   localparam int unsigned LIST_CNT_W = 7;
   localparam int unsigned POS_W      = 6;
   localparam int unsigned VALUE_W    = 32;

   typedef enum logic [1:0] {
      FUNC_PUSH_FRONT = 2'd0,
      FUNC_PUSH_BACK  = 2'd1,
      FUNC_REMOVE     = 2'd2,
      FUNC_RESERVED   = 2'd3
   } func_type;

   typedef struct packed {
      logic [1:0]                func;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] item_value;
      logic                      is_last;
      logic                      list_empty;
      logic                      ignored;
   } rsp_type;

   typedef enum logic [2:0] {
      CELL_HOLD   = 3'd0,
      CELL_FRONT  = 3'd1,
      CELL_BACK   = 3'd2,
      CELL_REMOVE = 3'd3,
      CELL_ROTATE = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type           op;
      logic [LIST_CNT_W-1:0] count;
      logic [POS_W-1:0]      position;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[rtl/core/blid_cell.sv]
`default_nettype none

module blid_cell #(
   parameter int unsigned IDX = 0
) (
   input  wire logic                                clock,
   input  wire blid_pkg::cell_ctrl_type             ctrl,
   input  wire logic signed [blid_pkg::VALUE_W-1:0] new_value,
   input  wire logic signed [blid_pkg::VALUE_W-1:0] left_value,
   input  wire logic signed [blid_pkg::VALUE_W-1:0] right_value,
   input  wire logic signed [blid_pkg::VALUE_W-1:0] head_value,
   output logic signed [blid_pkg::VALUE_W-1:0]      value_out
);
   import blid_pkg::*;

   localparam logic [LIST_CNT_W-1:0] MY_IDX  = LIST_CNT_W'(IDX);
   localparam logic [LIST_CNT_W-1:0] NXT_IDX = LIST_CNT_W'(IDX + 1);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      unique case (ctrl.op)
         CELL_FRONT: begin
            value_in = left_value;
         end
         CELL_BACK: begin
            if (ctrl.count == MY_IDX) begin
               value_in = new_value;
            end
         end
         CELL_REMOVE: begin
            // close the gap: everything at or past the removed slot moves down
            if (MY_IDX >= LIST_CNT_W'(ctrl.position)) begin
               value_in = right_value;
            end
         end
         CELL_ROTATE: begin
            // rotate only the occupied part so the order returns after count steps
            if (NXT_IDX < ctrl.count) begin
               value_in = right_value;
            end else if (NXT_IDX == ctrl.count) begin
               value_in = head_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule

`default_nettype wire

[rtl/core/bounded_list_insert_delete.sv]
`default_nettype none

// Channel  Dir  Transfer when          Carries
// req_     in   req_valid & req_ready  func, value, position
// rsp_     out  rsp_valid & rsp_ready  item_value, is_last, list_empty, ignored
//
// An operation is applied to the cell row in the cycle it is accepted; the
// listing then leaves at one result per cycle while rsp_ready is high,
// max(count,1) results in all, paced by rotating the cell row one step per
// result.
// Reset clears the count and control; cell contents are left as they are.
// A stalled rsp_ready holds the rotation; the next request is taken once the
// last result sits in the output register.

module bounded_list_insert_delete #(
   parameter int unsigned DEPTH = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire blid_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output blid_pkg::rsp_type      rsp_data
);
   import blid_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          ign_ff, ign_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   cell_ctrl_type             ctrl;
   logic signed [VALUE_W-1:0] cell_value [DEPTH];

   logic req_fire;
   logic load;
   logic is_full;
   logic pos_bad;
   logic last_now;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign load      = (state_ff == ST_EMIT) & (~rsp_valid_ff | rsp_ready);
   assign is_full   = (count_ff == CW'(DEPTH));
   assign pos_bad   = (LIST_CNT_W'(req_data.position) >= LIST_CNT_W'(count_ff));
   assign last_now  = (count_ff == '0) || ((idx_ff + CW'(1)) == count_ff);

   always_comb begin
      ctrl.op       = CELL_HOLD;
      ctrl.count    = LIST_CNT_W'(count_ff);
      ctrl.position = req_data.position;
      count_in      = count_ff;
      ign_in        = ign_ff;
      if (req_fire) begin
         unique case (func_type'(req_data.func))
            FUNC_PUSH_FRONT: begin
               ign_in = is_full;
               if (!is_full) begin
                  ctrl.op  = CELL_FRONT;
                  count_in = count_ff + CW'(1);
               end
            end
            FUNC_PUSH_BACK: begin
               ign_in = is_full;
               if (!is_full) begin
                  ctrl.op  = CELL_BACK;
                  count_in = count_ff + CW'(1);
               end
            end
            default: begin
               // reserved code acts as a removal
               ign_in = pos_bad;
               if (!pos_bad) begin
                  ctrl.op  = CELL_REMOVE;
                  count_in = count_ff - CW'(1);
               end
            end
         endcase
      end else if (load && count_ff != '0) begin
         ctrl.op = CELL_ROTATE;
      end
   end

   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic signed [VALUE_W-1:0] left_value;
         logic signed [VALUE_W-1:0] right_value;
         if (i == 0) begin : g_first
            assign left_value = req_data.value;
         end else begin : g_mid_l
            assign left_value = cell_value[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign right_value = cell_value[0];
         end else begin : g_mid_r
            assign right_value = cell_value[i+1];
         end
         blid_cell #(
            .IDX(i)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .new_value  (req_data.value),
            .left_value (left_value),
            .right_value(right_value),
            .head_value (cell_value[0]),
            .value_out  (cell_value[i])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EMIT;
               idx_in   = '0;
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.item_value = (count_ff == '0) ? '0 : cell_value[0];
               rsp_data_in.is_last    = last_now;
               rsp_data_in.list_empty = (count_ff == '0);
               rsp_data_in.ignored    = ign_ff;
               idx_in                 = idx_ff + CW'(1);
               if (last_now) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         ign_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         ign_ff       <= ign_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.list_empty) |-> rsp_data.is_last)
      else $error("empty listing not marked last");

   a_fire_emits: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_EMIT))
      else $error("accepted request did not start a listing");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_ignored_stable: assert property (@(posedge clock) disable iff (reset)
      (req_fire && ign_in) |=> $stable(count_ff))
      else $error("ignored operation changed the count");

endmodule

`default_nettype wire

[tb/sv/tb_bounded_list_insert_delete.sv]
`timescale 1ns / 1ps

module tb_bounded_list_insert_delete;
   import blid_pkg::*;

   localparam int unsigned LIST_DEPTH = 64;

   // Shadow copy of the bounded list: applies each accepted operation and
   // queues the listing the block is expected to emit for it.
   class listing_board;
      logic signed [VALUE_W-1:0] cells [LIST_DEPTH];
      int      cell_count;
      rsp_type expected_listing [$];
      int      errors;
      int      entries_checked;
      int      ops_applied;
      int      full_drops;
      int      bad_removes;
      int      peak_count;

      function new();
         cell_count      = 0;
         errors          = 0;
         entries_checked = 0;
         ops_applied     = 0;
         full_drops      = 0;
         bad_removes     = 0;
         peak_count      = 0;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function void apply_operation(req_type op);
         func_type f;
         bit       dropped;
         rsp_type  e;
         f       = func_type'(op.func);
         dropped = 1'b0;
         ops_applied++;
         case (f)
            FUNC_PUSH_FRONT: begin
               if (cell_count >= LIST_DEPTH) begin
                  dropped = 1'b1;
               end else begin
                  for (int i = cell_count; i > 0; i--) cells[i] = cells[i-1];
                  cells[0] = op.value;
                  cell_count++;
               end
            end
            FUNC_PUSH_BACK: begin
               if (cell_count >= LIST_DEPTH) begin
                  dropped = 1'b1;
               end else begin
                  cells[cell_count] = op.value;
                  cell_count++;
               end
            end
            // the reserved code behaves as a removal
            default: begin
               if (int'(op.position) >= cell_count) begin
                  dropped = 1'b1;
               end else begin
                  for (int i = int'(op.position); i < cell_count - 1; i++) cells[i] = cells[i+1];
                  cell_count--;
               end
            end
         endcase
         if (dropped) begin
            if (f == FUNC_PUSH_FRONT || f == FUNC_PUSH_BACK) full_drops++;
            else bad_removes++;
         end
         if (cell_count > peak_count) peak_count = cell_count;
         if (cell_count == 0) begin
            e.item_value = '0;
            e.is_last    = 1'b1;
            e.list_empty = 1'b1;
            e.ignored    = dropped;
            expected_listing.push_back(e);
         end else begin
            for (int k = 0; k < cell_count; k++) begin
               e.item_value = cells[k];
               e.is_last    = (k == cell_count - 1);
               e.list_empty = 1'b0;
               e.ignored    = dropped;
               expected_listing.push_back(e);
            end
         end
      endfunction

      task check_entry(rsp_type got);
         rsp_type want;
         if (expected_listing.size() == 0) begin
            report($sformatf("unexpected entry value=%0d last=%0b empty=%0b ignored=%0b",
                             got.item_value, got.is_last, got.list_empty, got.ignored));
            return;
         end
         want = expected_listing.pop_front();
         entries_checked++;
         if (got.item_value !== want.item_value)
            report($sformatf("entry %0d value got %0d want %0d",
                             entries_checked, got.item_value, want.item_value));
         if (got.is_last !== want.is_last)
            report($sformatf("entry %0d is_last got %b want %b",
                             entries_checked, got.is_last, want.is_last));
         if (got.list_empty !== want.list_empty)
            report($sformatf("entry %0d list_empty got %b want %b",
                             entries_checked, got.list_empty, want.list_empty));
         if (got.ignored !== want.ignored)
            report($sformatf("entry %0d ignored got %b want %b",
                             entries_checked, got.ignored, want.ignored));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int unsigned src_idle_pct;
   int unsigned rcv_stall_pct;
   bit          filling;

   listing_board board = new();

   bounded_list_insert_delete #(
      .DEPTH(LIST_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.apply_operation(req_data);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_entry(rsp_data);
   end

   function automatic req_type build_op(func_type f, logic signed [VALUE_W-1:0] v,
                                        logic [POS_W-1:0] p);
      req_type op;
      op.func     = f;
      op.value    = v;
      op.position = p;
      return op;
   endfunction

   // Hold valid high from the first cycle it rises until the transfer.
   task send_op(req_type op);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= op;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Alternate between growing the list to full and draining it to empty.
   task next_random_op(output req_type op);
      int unsigned roll;
      int          cnt;
      cnt = board.cell_count;
      if (cnt >= LIST_DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (cnt == 0 && $urandom_range(0, 1) == 0) filling = 1'b1;
      case ($urandom_range(0, 9))
         0:       op.value = 32'sh7FFF_FFFF;
         1:       op.value = 32'sh8000_0000;
         2:       op.value = $urandom_range(0, 15);
         default: op.value = $urandom;
      endcase
      op.position = POS_W'($urandom_range(0, 63));
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         op.func = FUNC_RESERVED;
      end else if (roll < (filling ? 90 : 20)) begin
         op.func = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
      end else begin
         op.func = FUNC_REMOVE;
      end
      if (op.func inside {FUNC_REMOVE, FUNC_RESERVED} && cnt > 0 && $urandom_range(0, 9) < 8)
         op.position = POS_W'($urandom_range(0, cnt - 1));
   endtask

   initial begin
      req_type op;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      src_idle_pct  = 0;
      rcv_stall_pct = 0;
      filling       = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // removals from an empty list, including the reserved code
      send_op(build_op(FUNC_REMOVE,     32'sd0,         6'd0));
      send_op(build_op(FUNC_RESERVED,   32'sd0,         6'd0));
      send_op(build_op(FUNC_PUSH_BACK,  32'sh7FFF_FFFF, 6'd63));
      send_op(build_op(FUNC_PUSH_FRONT, 32'sh8000_0000, 6'd0));
      send_op(build_op(FUNC_PUSH_BACK,  -32'sd1,        6'd21));
      send_op(build_op(FUNC_PUSH_FRONT, 32'sd0,         6'd42));
      send_op(build_op(FUNC_PUSH_BACK,  32'sh5555_5555, 6'd0));
      send_op(build_op(FUNC_PUSH_FRONT, 32'shAAAA_AAAA, 6'd63));
      // out of range: far past the end, then exactly at the count
      send_op(build_op(FUNC_REMOVE,     32'sd0,         6'd63));
      send_op(build_op(FUNC_REMOVE,     32'sd0,         6'd6));
      send_op(build_op(FUNC_REMOVE,     32'sd0,         6'd0));
      send_op(build_op(FUNC_REMOVE,     32'sd0,         6'd4));
      send_op(build_op(FUNC_RESERVED,   32'sd0,         6'd1));
      send_op(build_op(FUNC_REMOVE,     32'sd0,         6'd42));
      send_op(build_op(FUNC_REMOVE,     32'sd0,         6'd0));
      send_op(build_op(FUNC_REMOVE,     32'sd0,         6'd0));
      send_op(build_op(FUNC_REMOVE,     32'sd0,         6'd0));
      send_op(build_op(FUNC_PUSH_BACK,  32'sd1,         6'd0));
      send_op(build_op(FUNC_REMOVE,     32'sd0,         6'd0));

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin src_idle_pct = 59; rcv_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  rcv_stall_pct = 59; end
            default: begin src_idle_pct = 28; rcv_stall_pct = 28; end
         endcase
         repeat (120) begin
            next_random_op(op);
            send_op(op);
         end
      end
      req_valid <= 1'b0;

      while (board.expected_listing.size() != 0) @(posedge clock);
      // drain: catch any stray entries after the last listing
      repeat (LIST_DEPTH + 8) @(posedge clock);
      if (board.expected_listing.size() != 0)
         board.report($sformatf("%0d expected entries never arrived",
                                board.expected_listing.size()));

      $display("Ran %0d operations, checked %0d listing entries, longest list %0d.",
               board.ops_applied, board.entries_checked, board.peak_count);
      $display("Saw %0d inserts dropped on a full list and %0d out-of-range removals.",
               board.full_drops, board.bad_removes);
      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/blid_pkg.sv
rtl/core/blid_cell.sv
rtl/core/bounded_list_insert_delete.sv
tb/sv/tb_bounded_list_insert_delete.sv
